[design/adc_tci_pkg.sv]
// Shared types and constants for the ADC-to-temperature curve interpolator.
// No dependencies.
package adc_tci_pkg;

   localparam int ENTRY_W  = 12;
   localparam int IDX_W    = 5;
   localparam int BASE_W   = 7;
   localparam int TEMP_W   = 8;
   localparam int SUM_W    = 10;
   localparam int QUO_W    = 3;
   localparam int DIVD_W   = ENTRY_W + 3;

   localparam logic [BASE_W-1:0] BASE_RESET = 7'd12;
   localparam logic [SUM_W-1:0]  TEMP_MAX   = 10'd255;

   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INTERP     = 2'd0,
      STATUS_CLAMP_LOW  = 2'd1,
      STATUS_CLAMP_HIGH = 2'd2,
      STATUS_NO_SEGMENT = 2'd3
   } status_type;

endpackage

[design/adc_to_temperature_curve_interp_top.sv]
// Top level: thermistor ADC reading to temperature over a falling curve table.
// Depends on adc_tci_pkg, adc_tci_curve_ram, adc_tci_divider.
//
// Usage. A request beat is taken when start is high and busy is low.
// req_cmd = write stores req_adc_value into curve entry req_entry_index in
// that cycle; busy stays low and no response is produced. Indexes beyond the
// last entry are dropped. req_cmd = convert raises busy until the response.
// The response is a one-cycle rsp_valid strobe with rsp_temperature and
// rsp_status; the receiver cannot hold it off.
// A convert first compares the reading with entry 0 and clamps low if it is
// not below it, then with the last entry and clamps high if it is not above
// it, then scans the segments in order; a matching segment is followed by the
// serial divide, and if none matches the response reports no segment.
// The segment search reads one table entry per cycle from the single read
// port; the divide yields one quotient bit per cycle. A new convert is not
// taken until the previous response has been produced.
// csr_wr_en writes base temperature; write only while idle.
// Reset clears the sequencer and sets base temperature to 12; the curve
// table is not cleared and must be written before use.
module adc_to_temperature_curve_interp_top
   import adc_tci_pkg::*;
#(
   parameter int SEGMENTS = 22,
   parameter int ADC_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic [ENTRY_W-1:0] req_adc_value,
   output logic               rsp_valid,
   output logic [TEMP_W-1:0]  rsp_temperature,
   output logic [1:0]         rsp_status,
   input  logic               csr_wr_en,
   input  logic [BASE_W-1:0]  csr_wr_data
);

   localparam int ENTRIES = SEGMENTS + 1;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam logic [ENTRY_W-1:0] ADC_MASK =
      (ADC_BITS >= ENTRY_W) ? {ENTRY_W{1'b1}} : ENTRY_W'((1 << ADC_BITS) - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SEGMENTS);
   localparam logic [ADDR_W-1:0] LAST_SEG  = ADDR_W'(SEGMENTS - 1);
   localparam logic [SUM_W-1:0]  SPAN      = SUM_W'(4 * SEGMENTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_DIV
   } state_type;

   state_type          state_ff, state_in;
   logic [ENTRY_W-1:0] v_ff, v_in;
   logic [ENTRY_W-1:0] prev_ff, prev_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [BASE_W-1:0]  base_ff;
   logic               valid_ff, valid_in;
   logic [TEMP_W-1:0]  temp_ff, temp_in;
   status_type         status_ff, status_in;

   logic               accept;
   logic [ENTRY_W-1:0] adc_masked;
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] width;
   logic [DIVD_W-1:0]  dividend;
   logic               div_start;
   logic               div_done;
   logic [QUO_W-1:0]   quotient;
   logic [SUM_W-1:0]   sum;
   logic [TEMP_W-1:0]  sum_sat;

   function automatic logic [TEMP_W-1:0] sum_sat_high(input logic [BASE_W-1:0] base);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SPAN;
      return (s > TEMP_MAX) ? TEMP_W'(TEMP_MAX) : s[TEMP_W-1:0];
   endfunction

   assign accept     = start && !busy;
   assign adc_masked = req_adc_value & ADC_MASK;
   assign wr_en      = accept && (req_cmd == CMD_WRITE)
                       && (32'(req_entry_index) <= SEGMENTS);

   adc_tci_curve_ram #(
      .DEPTH  (ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (adc_masked),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign width    = prev_ff - rd_data;
   assign dividend = (DIVD_W'(prev_ff - v_ff) << 2) + DIVD_W'(width >> 1);

   adc_tci_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (width),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      case (state_ff)
         ST_FIRST: sum = SUM_W'(base_ff) + SPAN;
         default:  sum = SUM_W'(base_ff) + (SUM_W'(idx_ff) << 2) + SUM_W'(quotient);
      endcase
      sum_sat = (sum > TEMP_MAX) ? TEMP_W'(TEMP_MAX) : sum[TEMP_W-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      prev_in   = prev_ff;
      idx_in    = idx_ff;
      valid_in  = 1'b0;
      temp_in   = temp_ff;
      status_in = status_ff;
      rd_addr   = '0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_CONVERT)) begin
               v_in     = adc_masked;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            rd_addr = LAST_ADDR;
            if (v_ff >= rd_data) begin
               valid_in  = 1'b1;
               temp_in   = TEMP_W'(base_ff);
               status_in = STATUS_CLAMP_LOW;
               state_in  = ST_IDLE;
            end else begin
               prev_in  = rd_data;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            rd_addr = ADDR_W'(1);
            if (v_ff <= rd_data) begin
               valid_in  = 1'b1;
               temp_in   = sum_sat_high(base_ff);
               status_in = STATUS_CLAMP_HIGH;
               state_in  = ST_IDLE;
            end else begin
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff != LAST_SEG) begin
               rd_addr = idx_ff + ADDR_W'(2);
            end
            if ((v_ff > rd_data) && (v_ff <= prev_ff)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (idx_ff == LAST_SEG) begin
               valid_in  = 1'b1;
               temp_in   = '0;
               status_in = STATUS_NO_SEGMENT;
               state_in  = ST_IDLE;
            end else begin
               prev_in = rd_data;
               idx_in  = idx_ff + ADDR_W'(1);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               valid_in  = 1'b1;
               temp_in   = sum_sat;
               status_in = STATUS_INTERP;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         base_ff  <= BASE_RESET;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
      end
      v_ff      <= v_in;
      prev_ff   <= prev_in;
      idx_ff    <= idx_in;
      temp_ff   <= temp_in;
      status_ff <= status_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_temperature = temp_ff;
   assign rsp_status      = status_ff;

endmodule

[design/adc_tci_curve_ram.sv]
// Curve table storage: one write port, one registered read port.
// Depends on adc_tci_pkg.
module adc_tci_curve_ram
   import adc_tci_pkg::*;
#(
   parameter int DEPTH  = 23,
   parameter int ADDR_W = 5
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/adc_tci_divider.sv]
// Restoring divider, one quotient bit per cycle; quotient is known to be below 8.
// Depends on adc_tci_pkg.
module adc_tci_divider
   import adc_tci_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIVD_W-1:0]  dividend,
   input  logic [ENTRY_W-1:0] divisor,
   output logic               done,
   output logic [QUO_W-1:0]   quotient
);

   logic [DIVD_W-1:0]  rem_ff, rem_in;
   logic [ENTRY_W-1:0] div_ff, div_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [DIVD_W-1:0]  trial;
   logic               ge;

   assign trial = DIVD_W'(div_ff) << cnt_ff;
   assign ge    = rem_ff >= trial;

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         div_in = divisor;
         cnt_in = 2'(QUO_W - 1);
         quo_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[QUO_W-2:0], ge};
         if (ge) begin
            rem_in = rem_ff - trial;
         end
         if (cnt_ff == 2'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[design/adc_tci_checker.sv]
// Port-level checks for the curve interpolator top, bound to it below.
// Depends on adc_tci_pkg and adc_to_temperature_curve_interp_top.
module adc_tci_checker
   import adc_tci_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_cmd,
   input logic       rsp_valid
);

   // a convert beat holds the block busy
   a_convert_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_CONVERT) |=> busy)
      else $error("convert beat did not raise busy");

   // a write beat never yields a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_WRITE) |=> !busy && !rsp_valid)
      else $error("write beat produced busy or a response");

   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy ##1 !rsp_valid)
      else $error("response overlaps busy or repeats");

endmodule

bind adc_to_temperature_curve_interp_top adc_tci_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_cmd    (req_cmd),
   .rsp_valid  (rsp_valid)
);
